@@ src/msps_pkg.sv @@
// shared types and constants for the multi-policy scheduler
package msps_pkg;

    localparam logic [1:0] POL_SJF  = 2'd0;
    localparam logic [1:0] POL_PRIO = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;
    localparam logic [1:0] POL_FCFS = 2'd3;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] CFG_POLICY  = 2'd0;
    localparam logic [1:0] CFG_PREEMPT = 2'd1;
    localparam logic [1:0] CFG_QUANTUM = 2'd2;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] remaining;
        logic [7:0]  priority_num;
        logic [15:0] stamp;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic cand_vld;
    } pick_ctl_t;

endpackage

@@ src/msps_ram.sv @@
// generic single-port-write ram with registered read
module msps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/msps_pick.sv @@
// shared compare unit keeping the best candidate of a table scan
module msps_pick #(
    parameter int SLOT_W = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  msps_pkg::pick_ctl_t ctl,
    input  logic [15:0]        cand_key,
    input  logic [15:0]        cand_age,
    input  logic [SLOT_W-1:0]  cand_slot,
    input  msps_pkg::entry_t   cand_data,
    output logic               best_vld,
    output logic [SLOT_W-1:0]  best_slot,
    output msps_pkg::entry_t   best_data
);
    logic             best_vld_reg, best_vld_next;
    logic [15:0]      best_key_reg, best_age_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    msps_pkg::entry_t best_data_reg;
    logic             take;

    // strict win only: a key tie goes to the older entry (larger age), a full tie stays with the lower slot
    assign take = ctl.cand_vld && (!best_vld_reg || cand_key < best_key_reg ||
                  (cand_key == best_key_reg && cand_age > best_age_reg));

    always_comb begin
        best_vld_next = best_vld_reg;
        if (ctl.clear) begin
            best_vld_next = 1'b0;
        end else if (take) begin
            best_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_vld_reg <= 1'b0;
        end else begin
            best_vld_reg <= best_vld_next;
        end
        if (!ctl.clear && take) begin
            best_key_reg  <= cand_key;
            best_age_reg  <= cand_age;
            best_slot_reg <= cand_slot;
            best_data_reg <= cand_data;
        end
    end

    assign best_vld  = best_vld_reg;
    assign best_slot = best_slot_reg;
    assign best_data = best_data_reg;
endmodule

@@ src/multi_policy_process_scheduler_core.sv @@
// top level of the multi-policy process scheduler
// One word in, one word out. An add scans the valid bits for the first free
// slot, one slot per cycle, and a zero-burst add goes straight to the output.
// A tick either reads the held running process or scans the whole slot ram
// through the shared compare unit, one entry per cycle. The slot ram has one
// read port, and that scan sets the tick time. No clearing pass after reset:
// slot contents are only read behind valid bits that reset clears. Input is
// not ready while a word is in work or its result waits on the output.
module multi_policy_process_scheduler_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_proc_id,
    input  logic [15:0] s_proc_burst,
    input  logic [7:0]  s_proc_priority,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_run_id,
    output logic        m_completed,
    output logic [31:0] m_finish_time,
    output logic        m_all_idle,
    output logic        m_table_full
);
    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W  = $bits(msps_pkg::entry_t);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FIND   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_LAST   = 3'd3;
    localparam logic [2:0] ST_PICKED = 3'd4;
    localparam logic [2:0] ST_RDWAIT = 3'd5;
    localparam logic [2:0] ST_EXEC   = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [1:0] policy_reg;
    logic       preempt_reg;
    logic [7:0] quantum_reg;

    // latched input word
    logic        op_reg;
    logic [7:0]  id_reg;
    logic [15:0] burst_reg;
    logic [7:0]  prio_reg;

    // scheduler state
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [15:0]       stamp_reg, stamp_next;
    logic              run_vld_reg, run_vld_next;
    logic [SLOT_W-1:0] run_slot_reg, run_slot_next;
    logic [15:0]       slice_reg, slice_next;
    logic [31:0]       tick_reg, tick_next;
    logic              repick_reg, repick_next;

    // scan and current process
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [SLOT_W-1:0] cmp_slot_reg;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    msps_pkg::entry_t  cur_reg, cur_next;

    // output word
    logic [7:0]  o_id_reg, o_id_next;
    logic        o_fin_reg, o_fin_next;
    logic [31:0] o_time_reg, o_time_next;
    logic        o_full_reg, o_full_next;

    // ram
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    msps_pkg::entry_t  ram_wdata, ram_rdata;
    logic [ENT_W-1:0]  ram_rbits;

    // compare unit
    msps_pkg::pick_ctl_t pick_ctl;
    logic [15:0]       cand_key;
    logic              best_vld;
    logic [SLOT_W-1:0] best_slot;
    msps_pkg::entry_t  best_data;

    logic [7:0]  q_eff;
    logic [15:0] rem_dec, slice_dec;
    logic        in_acc;

    assign in_acc  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign ram_rdata = msps_pkg::entry_t'(ram_rbits);

    msps_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    // key by policy, age against the next stamp
    always_comb begin
        case (policy_reg)
            msps_pkg::POL_SJF:  cand_key = ram_rdata.remaining;
            msps_pkg::POL_PRIO: cand_key = {8'd0, ram_rdata.priority_num};
            default:            cand_key = 16'd0;
        endcase
    end

    assign pick_ctl.clear    = in_acc;
    assign pick_ctl.cand_vld = cmp_vld_reg && (state_reg == ST_SCAN || state_reg == ST_LAST);

    msps_pick #(.SLOT_W(SLOT_W)) u_pick (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (pick_ctl),
        .cand_key  (cand_key),
        .cand_age  (stamp_reg - ram_rdata.stamp),
        .cand_slot (cmp_slot_reg),
        .cand_data (ram_rdata),
        .best_vld  (best_vld),
        .best_slot (best_slot),
        .best_data (best_data)
    );

    assign q_eff     = (quantum_reg == 8'd0) ? 8'd1 : quantum_reg;
    assign rem_dec   = cur_reg.remaining - 16'd1;
    assign slice_dec = (slice_reg != 16'd0) ? slice_reg - 16'd1 : 16'd0;

    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        stamp_next    = stamp_reg;
        run_vld_next  = run_vld_reg;
        run_slot_next = run_slot_reg;
        slice_next    = slice_reg;
        tick_next     = tick_reg;
        repick_next   = repick_reg;
        idx_next      = idx_reg;
        cmp_vld_next  = 1'b0;
        cur_slot_next = cur_slot_reg;
        cur_next      = cur_reg;
        o_id_next     = o_id_reg;
        o_fin_next    = o_fin_reg;
        o_time_next   = o_time_reg;
        o_full_next   = o_full_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = cur_reg;
        ram_raddr     = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    o_id_next   = 8'd0;
                    o_fin_next  = 1'b0;
                    o_time_next = 32'd0;
                    o_full_next = 1'b0;
                    idx_next    = '0;
                    if (s_opcode == msps_pkg::OP_ADD) begin
                        // zero burst is dropped silently
                        state_next = (s_proc_burst == 16'd0) ? ST_OUT : ST_FIND;
                    end else begin
                        repick_next = (policy_reg == msps_pkg::POL_SJF ||
                                       policy_reg == msps_pkg::POL_PRIO) && preempt_reg;
                        if (repick_next) begin
                            run_vld_next = 1'b0;
                            state_next   = ST_SCAN;
                        end else if (run_vld_reg && valid_reg[run_slot_reg]) begin
                            ram_raddr     = run_slot_reg;
                            cur_slot_next = run_slot_reg;
                            state_next    = ST_RDWAIT;
                        end else begin
                            run_vld_next = 1'b0;
                            state_next   = ST_SCAN;
                        end
                    end
                end
            end
            ST_FIND: begin
                // first free slot, one per cycle
                if (!valid_reg[idx_reg]) begin
                    ram_we          = 1'b1;
                    ram_waddr       = idx_reg;
                    ram_wdata.id    = id_reg;
                    ram_wdata.remaining    = burst_reg;
                    ram_wdata.priority_num = prio_reg;
                    ram_wdata.stamp = stamp_reg;
                    valid_next[idx_reg] = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    stamp_next = stamp_reg + 16'd1;
                    state_next = ST_OUT;
                end else if (idx_reg == LAST_SLOT) begin
                    o_full_next = 1'b1;
                    state_next  = ST_OUT;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_SCAN: begin
                ram_raddr    = idx_reg;
                cmp_vld_next = valid_reg[idx_reg];
                if (idx_reg == LAST_SLOT) begin
                    state_next = ST_LAST;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_LAST: begin
                state_next = ST_PICKED;
            end
            ST_PICKED: begin
                if (!best_vld) begin
                    // nothing ready, idle tick
                    tick_next  = tick_reg + 32'd1;
                    state_next = ST_OUT;
                end else begin
                    cur_next      = best_data;
                    cur_slot_next = best_slot;
                    if (!repick_reg) begin
                        run_vld_next  = 1'b1;
                        run_slot_next = best_slot;
                        slice_next    = (best_data.remaining < {8'd0, q_eff}) ?
                                        best_data.remaining : {8'd0, q_eff};
                    end
                    state_next = ST_EXEC;
                end
            end
            ST_RDWAIT: begin
                cur_next   = ram_rdata;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                o_id_next  = cur_reg.id;
                slice_next = slice_dec;
                tick_next  = tick_reg + 32'd1;
                ram_waddr  = cur_slot_reg;
                ram_wdata.remaining = rem_dec;
                if (rem_dec == 16'd0) begin
                    o_fin_next  = 1'b1;
                    o_time_next = tick_reg + 32'd1;
                    valid_next[cur_slot_reg] = 1'b0;
                    count_next   = count_reg - CNT_W'(1);
                    run_vld_next = 1'b0;
                end else begin
                    ram_we = 1'b1;
                    // round robin slice over: requeue at the tail
                    if (!repick_reg && policy_reg == msps_pkg::POL_RR &&
                        slice_dec == 16'd0) begin
                        ram_wdata.stamp = stamp_reg;
                        stamp_next   = stamp_reg + 16'd1;
                        run_vld_next = 1'b0;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            policy_reg  <= msps_pkg::POL_FCFS;
            preempt_reg <= 1'b0;
            quantum_reg <= 8'd2;
            valid_reg   <= '0;
            count_reg   <= '0;
            stamp_reg   <= 16'd0;
            run_vld_reg <= 1'b0;
            run_slot_reg <= '0;
            slice_reg   <= 16'd0;
            tick_reg    <= 32'd0;
            repick_reg  <= 1'b0;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            stamp_reg   <= stamp_next;
            run_vld_reg <= run_vld_next;
            run_slot_reg <= run_slot_next;
            slice_reg   <= slice_next;
            tick_reg    <= tick_next;
            repick_reg  <= repick_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            if (cfg_we) begin
                case (cfg_index)
                    msps_pkg::CFG_POLICY:  policy_reg  <= cfg_data[1:0];
                    msps_pkg::CFG_PREEMPT: preempt_reg <= cfg_data[0];
                    msps_pkg::CFG_QUANTUM: quantum_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        // payload, no reset
        if (in_acc) begin
            op_reg    <= s_opcode;
            id_reg    <= s_proc_id;
            burst_reg <= s_proc_burst;
            prio_reg  <= s_proc_priority;
        end
        cmp_slot_reg <= idx_reg;
        cur_slot_reg <= cur_slot_next;
        cur_reg      <= cur_next;
        o_id_reg     <= o_id_next;
        o_fin_reg    <= o_fin_next;
        o_time_reg   <= o_time_next;
        o_full_reg   <= o_full_next;
    end

    // table_full only ever set on the add path
    assign m_run_id      = o_id_reg;
    assign m_completed   = o_fin_reg;
    assign m_finish_time = o_time_reg;
    assign m_all_idle    = (count_reg == '0);
    assign m_table_full  = o_full_reg && (op_reg == msps_pkg::OP_ADD);
endmodule
